[src/allpass_phaser_core_defines.svh]
// Assertion macros for the allpass phaser core.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef ALLPASS_PHASER_CORE_DEFINES_SVH
`define ALLPASS_PHASER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define APPH_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apph check failed");
`define APPH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apph check failed");
`else
`define APPH_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define APPH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/apph_pkg.sv]
// Shared types, constants and arithmetic helpers of the allpass phaser core.
// No dependencies.
package apph_pkg;

  localparam int MAX_STAGES_DEF       = 12;
  localparam int SAMPLE_RATE_DEF      = 48000;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int COEF_TABLE_DEPTH_DEF = 1024;

  localparam int STG_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_LFO_INC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO   = 3'd4;

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  localparam logic signed [15:0] FB_LIMIT = 16'sd31130;
  localparam logic signed [47:0] ST_MAX   = 48'sd134217727;
  localparam logic signed [47:0] ST_MIN   = -48'sd134217728;
  localparam logic signed [47:0] OUT_MAX  = 48'sd8388607;
  localparam logic signed [47:0] OUT_MIN  = -48'sd8388608;

  typedef struct packed {
    logic signed [23:0] sample_left;
    logic signed [23:0] sample_right;
    logic               block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic               out_block_last;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic               release_lane;
    logic signed [23:0] dry;
    logic [31:0]        phase;
    logic [15:0]        depth;
    logic signed [15:0] fb;
    logic [STG_W-1:0]   stages;
  } lane_ctl_t;

  typedef struct packed {
    logic               done;
    logic signed [23:0] result;
  } lane_stat_t;

  // restoring shift-and-subtract quotient, used only while building tables
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  function automatic longint sin_q30(input longint unsigned a_in);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    bit              neg;
    a    = a_in - udiv64(a_in, TWO_PI_Q30) * TWO_PI_Q30;
    neg  = 1'b0;
    if (a >= PI_Q30) begin
      a   = a - PI_Q30;
      neg = 1'b1;
    end
    if (a > HALF_PI_Q30) a = PI_Q30 - a;
    x2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    for (int k = 1; k <= 7; k++) begin
      term = udiv64((term * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
      if ((k & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return neg ? -sum : sum;
  endfunction

  function automatic logic signed [47:0] rshift_rnd(input logic signed [47:0] v, input int n);
    return (v + (48'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [27:0] sat_st(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
    return r[27:0];
  endfunction

  function automatic logic signed [23:0] sat_out(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
    return r[23:0];
  endfunction

endpackage

[src/apph_coef.sv]
// LFO phase to allpass coefficient pipeline: sine ROM, depth scaling, coefficient ROM.
// Depends on apph_pkg; ROM contents are built at elaboration.
module apph_coef #(
  parameter int SAMPLE_RATE      = apph_pkg::SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = apph_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int COEF_TABLE_DEPTH = apph_pkg::COEF_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic [31:0]        phase,
  input  logic [15:0]        depth,
  output logic signed [17:0] coef
);
  import apph_pkg::*;

  localparam int SIW = $clog2(SINE_TABLE_DEPTH);
  localparam int CIW = $clog2(COEF_TABLE_DEPTH);

  typedef logic [16:0]        sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic signed [17:0] coef_rom_t [COEF_TABLE_DEPTH];

  function automatic sine_rom_t build_sine();
    sine_rom_t t;
    longint    s;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      s    = sin_q30(udiv64(TWO_PI_Q30 * longint'(i), longint'(SINE_TABLE_DEPTH)));
      t[i] = 17'((ONE_Q30 + s + 16384) >>> 15);
    end
    return t;
  endfunction

  function automatic coef_rom_t build_coef();
    coef_rom_t       t;
    longint unsigned dm1;
    longint unsigned th;
    longint unsigned an;
    longint unsigned ad;
    longint unsigned q;
    longint          s;
    longint          c;
    longint          num;
    longint          den;
    longint          v;
    dm1 = longint'(COEF_TABLE_DEPTH - 1);
    for (int i = 0; i < COEF_TABLE_DEPTH; i++) begin
      th  = udiv64(PI_Q30 * (200 * dm1 + 5800 * longint'(i)),
                   longint'(SAMPLE_RATE) * dm1);
      s   = sin_q30(th);
      c   = sin_q30(th + HALF_PI_Q30);
      num = s - c;
      den = s + c;
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      if (ad == 0) begin
        v = 131071;
      end else begin
        q = udiv64((an << 17) + (ad >> 1), ad);
        if (q > 131072) q = 131072;
        v = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        if (v > 131071) v = 131071;
      end
      t[i] = 18'(v);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam coef_rom_t COEF_ROM = build_coef();

  logic [63:0]    sprod;
  logic [63:0]    cprod;
  logic [SIW-1:0] sidx;
  logic [16:0]    lfo;
  logic [32:0]    u;
  logic [CIW-1:0] cidx;

  assign sprod = 64'(phase) * 64'(SINE_TABLE_DEPTH);
  assign cprod = 64'(u) * 64'(COEF_TABLE_DEPTH - 1) + 64'h8000_0000;

  always_ff @(posedge clk) begin
    sidx <= sprod[32 +: SIW];
    lfo  <= SINE_ROM[sidx];
    u    <= 33'(lfo) * 33'(depth);
    cidx <= cprod[32 +: CIW];
    coef <= COEF_ROM[cidx];
  end

endmodule

[src/apph_lane.sv]
// One channel lane: feedback, iterated first-order allpass sections and dry/wet mix.
// Depends on apph_pkg and apph_coef.
module apph_lane #(
  parameter int MAX_STAGES       = apph_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_RATE      = apph_pkg::SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = apph_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int COEF_TABLE_DEPTH = apph_pkg::COEF_TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  apph_pkg::lane_ctl_t  ctl,
  output apph_pkg::lane_stat_t stat
);
  import apph_pkg::*;

  localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam logic [2:0] COEF_LAT = 3'd5;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_COEF = 4'd1;
  localparam logic [3:0] S_A1   = 4'd2;
  localparam logic [3:0] S_A2   = 4'd3;
  localparam logic [3:0] S_B1   = 4'd4;
  localparam logic [3:0] S_B2   = 4'd5;
  localparam logic [3:0] S_MIX1 = 4'd6;
  localparam logic [3:0] S_MIX2 = 4'd7;
  localparam logic [3:0] S_MIX3 = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]         st;
  logic [2:0]         wcnt;
  logic [IW-1:0]      sidx;
  logic [31:0]        phase_q;
  logic signed [23:0] dry;
  logic signed [17:0] c;
  logic signed [17:0] coef;
  logic signed [27:0] x;
  logic signed [27:0] y;
  logic signed [27:0] last;
  logic signed [27:0] mem [MAX_STAGES];
  logic signed [47:0] pa;
  logic signed [47:0] pb;
  logic signed [23:0] res;
  logic signed [18:0] dry_w;

  apph_coef #(
    .SAMPLE_RATE      (SAMPLE_RATE),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COEF_TABLE_DEPTH (COEF_TABLE_DEPTH)
  ) u_coef (
    .clk   (clk),
    .phase (phase_q),
    .depth (ctl.depth),
    .coef  (coef)
  );

  assign dry_w = 19'sd131072 - $signed({3'b000, ctl.depth});

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      wcnt <= '0;
      sidx <= '0;
      last <= '0;
      for (int i = 0; i < MAX_STAGES; i++) mem[i] <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (ctl.start) begin
            phase_q <= ctl.phase;
            dry     <= ctl.dry;
            pa      <= 48'(last) * 48'(ctl.fb);
            wcnt    <= '0;
            sidx    <= '0;
            st      <= S_COEF;
          end
        end
        S_COEF: begin
          wcnt <= wcnt + 3'd1;
          if (wcnt == 3'd0) x <= sat_st(48'(dry) + rshift_rnd(pa, 15));
          if (wcnt == COEF_LAT) begin
            c  <= coef;
            st <= S_A1;
          end
        end
        S_A1: begin
          pa <= 48'(c) * 48'(x);
          st <= S_A2;
        end
        S_A2: begin
          y  <= sat_st(rshift_rnd(pa, 17) + 48'(mem[sidx]));
          st <= S_B1;
        end
        S_B1: begin
          pa <= 48'(c) * 48'(y);
          st <= S_B2;
        end
        S_B2: begin
          mem[sidx] <= sat_st(48'(x) - rshift_rnd(pa, 17));
          x         <= y;
          if (STG_W'(sidx) == ctl.stages - STG_W'(1)) begin
            st <= S_MIX1;
          end else begin
            sidx <= sidx + IW'(1);
            st   <= S_A1;
          end
        end
        S_MIX1: begin
          last <= x;
          pa   <= 48'(dry) * 48'(dry_w);
          st   <= S_MIX2;
        end
        S_MIX2: begin
          pb <= 48'(x) * 48'($signed({1'b0, ctl.depth}));
          st <= S_MIX3;
        end
        S_MIX3: begin
          res <= sat_out(rshift_rnd(pa + pb, 17));
          st  <= S_DONE;
        end
        S_DONE: begin
          if (ctl.release_lane) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign stat.done   = (st == S_DONE);
  assign stat.result = res;

endmodule

[src/allpass_phaser_core.sv]
// A new input frame is accepted only while no frame is held in the lanes (in_stall = busy).
// Each lane reuses its allpass multiplier for the two multiplies of every section;
// the lanes run left and right in parallel.
// The output register lets the next frame enter while a result waits.
// Reset (rst, synchronous): configuration registers to defaults, LFO phase and section memories cleared.
module allpass_phaser_core #(
  parameter int MAX_STAGES       = apph_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_RATE      = apph_pkg::SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = apph_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int COEF_TABLE_DEPTH = apph_pkg::COEF_TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  apph_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output apph_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [apph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apph_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import apph_pkg::*;
  `include "allpass_phaser_core_defines.svh"

  logic [19:0]        lfo_inc;
  logic [15:0]        depth;
  logic signed [15:0] fb_gain;
  logic [3:0]         stage_cnt;
  logic               stereo_en;
  logic [31:0]        phase;
  logic               busy;
  logic               right_on;
  logic signed [23:0] dry_r;
  logic               last_r;
  logic               accept;
  logic               collect;
  logic signed [15:0] fb_eff;
  logic [STG_W-1:0]   stg_eff;
  lane_ctl_t          ctl_l;
  lane_ctl_t          ctl_r;
  lane_stat_t         stat_l;
  lane_stat_t         stat_r;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign collect  = busy && stat_l.done && (!right_on || stat_r.done) &&
                    (!out_valid || !out_stall);

  assign fb_eff  = (fb_gain > FB_LIMIT) ? FB_LIMIT :
                   ((fb_gain < -FB_LIMIT) ? -FB_LIMIT : fb_gain);
  assign stg_eff = (stage_cnt < 4'd2) ? STG_W'(2) :
                   ((STG_W'(stage_cnt) > STG_W'(MAX_STAGES)) ? STG_W'(MAX_STAGES) :
                    STG_W'(stage_cnt));

  always_comb begin
    ctl_l.start        = accept;
    ctl_l.release_lane = collect;
    ctl_l.dry          = in_data.sample_left;
    ctl_l.phase        = phase;
    ctl_l.depth        = depth;
    ctl_l.fb           = fb_eff;
    ctl_l.stages       = stg_eff;
    ctl_r              = ctl_l;
    ctl_r.start        = accept && stereo_en;
    ctl_r.dry          = in_data.sample_right;
    ctl_r.phase        = phase + 32'h8000_0000;
  end

  apph_lane #(
    .MAX_STAGES       (MAX_STAGES),
    .SAMPLE_RATE      (SAMPLE_RATE),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COEF_TABLE_DEPTH (COEF_TABLE_DEPTH)
  ) u_lane_l (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_l),
    .stat (stat_l)
  );

  apph_lane #(
    .MAX_STAGES       (MAX_STAGES),
    .SAMPLE_RATE      (SAMPLE_RATE),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COEF_TABLE_DEPTH (COEF_TABLE_DEPTH)
  ) u_lane_r (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_r),
    .stat (stat_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_inc   <= 20'd17895;
      depth     <= 16'd32768;
      fb_gain   <= '0;
      stage_cnt <= 4'd4;
      stereo_en <= 1'b1;
      phase     <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LFO_INC:  lfo_inc   <= cfg_wdata;
          REG_DEPTH:    depth     <= cfg_wdata[15:0];
          REG_FEEDBACK: fb_gain   <= cfg_wdata[15:0];
          REG_STAGES:   stage_cnt <= cfg_wdata[3:0];
          REG_STEREO:   stereo_en <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        busy     <= 1'b1;
        right_on <= stereo_en;
        dry_r    <= in_data.sample_right;
        last_r   <= in_data.block_last;
        phase    <= phase + 32'(lfo_inc);
      end
      if (collect) begin
        busy                    <= 1'b0;
        out_valid               <= 1'b1;
        out_data.out_left       <= stat_l.result;
        out_data.out_right      <= right_on ? stat_r.result : dry_r;
        out_data.out_block_last <= last_r;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `APPH_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall)
  `APPH_ASSERT_IMPL(a_collect_left_done, clk, rst, collect, stat_l.done)
  `APPH_ASSERT_IMPL(a_collect_right_done, clk, rst, collect && right_on, stat_r.done)
  `APPH_ASSERT_IMPL(a_no_done_when_idle, clk, rst, !busy, !stat_l.done)

endmodule
